// ===== hw/rtl/ata_rd_pkg.sv =====
// shared types, codes and constants for the ata pio lba28 sector reader
// used by ata_rd_step, ata_pio_sector_reader and ata_rd_checker
package ata_rd_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int DISCARD_READS    = 5;
    localparam int MAX_RES          = 6;
    localparam int CNT_W            = $clog2(MAX_RES + 1);

    // input kinds (s_tuser)
    localparam logic IN_START  = 1'b0;
    localparam logic IN_ANSWER = 1'b1;

    // result kinds (m_tuser)
    localparam logic [1:0] RK_READ   = 2'd0;
    localparam logic [1:0] RK_WRITE  = 2'd1;
    localparam logic [1:0] RK_DATA   = 2'd2;
    localparam logic [1:0] RK_REJECT = 2'd3;

    // sequencer phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_WAIT_FREE = 4'd1;
    localparam logic [3:0] PH_WAIT_HEAD = 4'd2;
    localparam logic [3:0] PH_WAIT_DRQ  = 4'd3;
    localparam logic [3:0] PH_DATA      = 4'd4;

    // register offsets from the task file base
    localparam logic [2:0] OFF_DATA   = 3'd0;
    localparam logic [2:0] OFF_COUNT  = 3'd2;
    localparam logic [2:0] OFF_LBA0   = 3'd3;
    localparam logic [2:0] OFF_LBA1   = 3'd4;
    localparam logic [2:0] OFF_LBA2   = 3'd5;
    localparam logic [2:0] OFF_HEAD   = 3'd6;
    localparam logic [2:0] OFF_STATUS = 3'd7;

    localparam logic [7:0] ST_BSY        = 8'h80;
    localparam logic [7:0] ST_DRQ        = 8'h08;
    localparam logic [7:0] HEAD_LBA_BITS = 8'hE0;
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] ONE_SECTOR    = 8'h01;

    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  discard_count;
        logic [7:0]  words_read;
        logic [27:0] lba;
    } ctrl_state_t;

    typedef struct packed {
        logic        sector_done;
        logic [7:0]  word_index;
        logic [15:0] data_word;
        logic [7:0]  write_value;
        logic [2:0]  port_offset;
        logic [1:0]  result_kind;
    } result_t;

    function automatic result_t mk_read(input logic [2:0] port);
        result_t r;
        r             = '0;
        r.result_kind = RK_READ;
        r.port_offset = port;
        return r;
    endfunction

    function automatic result_t mk_write(input logic [2:0] port, input logic [7:0] val);
        result_t r;
        r             = '0;
        r.result_kind = RK_WRITE;
        r.port_offset = port;
        r.write_value = val;
        return r;
    endfunction

    function automatic result_t mk_word(input logic [15:0] word, input logic [7:0] idx,
                                        input logic done);
        result_t r;
        r             = '0;
        r.result_kind = RK_DATA;
        r.data_word   = word;
        r.word_index  = idx;
        r.sector_done = done;
        return r;
    endfunction

endpackage

// ===== hw/rtl/ata_rd_step.sv =====
// next-state and result-list logic for one input beat of the sector reader
// depends on ata_rd_pkg
module ata_rd_step
    import ata_rd_pkg::*;
(
    input  ctrl_state_t                cur,
    input  logic                       in_kind,
    input  logic [27:0]                in_sector,
    input  logic [15:0]                in_read_data,
    output ctrl_state_t                nxt,
    output result_t [MAX_RES-1:0]      res,
    output logic [CNT_W-1:0]           res_cnt
);

    localparam logic [2:0] DISCARD_LIM = 3'(DISCARD_READS);
    localparam logic [8:0] WPS         = 9'(WORDS_PER_SECTOR);

    logic [3:0] ph;
    logic [7:0] status;
    logic       word_done;

    assign status    = in_read_data[7:0];
    assign word_done = ({1'b0, cur.words_read} + 9'd1) >= WPS;

    always_comb begin
        // out-of-range phase codes behave as idle
        ph        = (cur.phase > PH_DATA) ? PH_IDLE : cur.phase;
        nxt       = cur;
        nxt.phase = ph;
        res       = '0;
        res_cnt   = '0;

        if (in_kind == IN_START) begin
            if (ph != PH_IDLE) begin
                res[0]             = '0;
                res[0].result_kind = RK_REJECT;
                res_cnt            = CNT_W'(1);
            end else begin
                nxt.lba           = in_sector;
                nxt.words_read    = '0;
                nxt.phase         = PH_WAIT_FREE;
                nxt.discard_count = '0;
                res[0]            = mk_read(OFF_STATUS);
                res_cnt           = CNT_W'(1);
            end
        end else begin
            case (ph) inside
                PH_WAIT_FREE, PH_WAIT_HEAD, PH_WAIT_DRQ: begin
                    if (cur.discard_count < DISCARD_LIM) begin
                        nxt.discard_count = cur.discard_count + 3'd1;
                        res[0]            = mk_read(OFF_STATUS);
                        res_cnt           = CNT_W'(1);
                    end else if (ph == PH_WAIT_FREE) begin
                        if ((status & ST_BSY) != 8'h00) begin
                            res[0]  = mk_read(OFF_STATUS);
                            res_cnt = CNT_W'(1);
                        end else begin
                            res[0]  = mk_write(OFF_HEAD, {4'h0, cur.lba[27:24]} | HEAD_LBA_BITS);
                            res[1]  = mk_read(OFF_STATUS);
                            res_cnt = CNT_W'(2);
                            nxt.phase         = PH_WAIT_HEAD;
                            nxt.discard_count = '0;
                        end
                    end else if (ph == PH_WAIT_HEAD) begin
                        if ((status & ST_BSY) != 8'h00) begin
                            res[0]  = mk_read(OFF_STATUS);
                            res_cnt = CNT_W'(1);
                        end else begin
                            res[0]  = mk_write(OFF_LBA0, cur.lba[7:0]);
                            res[1]  = mk_write(OFF_LBA1, cur.lba[15:8]);
                            res[2]  = mk_write(OFF_LBA2, cur.lba[23:16]);
                            res[3]  = mk_write(OFF_COUNT, ONE_SECTOR);
                            res[4]  = mk_write(OFF_STATUS, CMD_READ);
                            res[5]  = mk_read(OFF_STATUS);
                            res_cnt = CNT_W'(6);
                            nxt.phase         = PH_WAIT_DRQ;
                            nxt.discard_count = '0;
                        end
                    end else begin
                        if ((status & ST_DRQ) != ST_DRQ) begin
                            res[0]  = mk_read(OFF_STATUS);
                            res_cnt = CNT_W'(1);
                        end else begin
                            nxt.phase = PH_DATA;
                            res[0]    = mk_read(OFF_DATA);
                            res_cnt   = CNT_W'(1);
                        end
                    end
                end
                PH_DATA: begin
                    res[0] = mk_word(in_read_data, cur.words_read, word_done);
                    if (word_done) begin
                        nxt.phase      = PH_IDLE;
                        nxt.words_read = '0;
                        res_cnt        = CNT_W'(1);
                    end else begin
                        nxt.words_read = cur.words_read + 8'd1;
                        res[1]         = mk_read(OFF_DATA);
                        res_cnt        = CNT_W'(2);
                    end
                end
                default: begin
                    // answer while idle is dropped
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/ata_pio_sector_reader.sv =====
// Host-side ATA PIO LBA28 single-sector read engine. A start beat (s_tuser = 0)
// latches a 28-bit sector; the engine then emits bus read/write requests on the
// master side and takes each bus read's answer as an s_tuser = 1 beat. Status
// waits issue five discarded status reads before polling; polling never times
// out. Each input beat's results are loaded into a six-entry result register
// that drains one beat per cycle while m_tready is high; a new input beat is
// taken in the same cycle that the last pending result leaves. Most input
// beats cause one result, so the engine sustains one beat per cycle when
// m_tready stays high; the command issue step causes six results, and a data
// word with its next read request causes two. No new input beat is taken
// until every result of the last one has left. A start while busy returns
// one rejected beat.
// depends on ata_rd_pkg and ata_rd_step
module ata_pio_sector_reader
    import ata_rd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [27:0] sector, [43:28] read_data, [47:44] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] port_offset, [10:3] write_value,
                                   // [26:11] data_word, [34:27] word_index,
                                   // [35] sector_done, [39:36] zero
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast
);

    ctrl_state_t            st_reg, st_next, st_step;
    result_t [MAX_RES-1:0]  q_reg, q_next, step_res;
    logic [CNT_W-1:0]       cnt_reg, cnt_next, step_cnt;
    logic                   s_take, m_take;

    ata_rd_step u_step (
        .cur          (st_reg),
        .in_kind      (s_tuser),
        .in_sector    (s_tdata[27:0]),
        .in_read_data (s_tdata[43:28]),
        .nxt          (st_step),
        .res          (step_res),
        .res_cnt      (step_cnt)
    );

    assign m_tvalid = (cnt_reg != '0);
    assign m_take   = m_tvalid && m_tready;
    // free when empty or when the final pending beat leaves this cycle
    assign s_tready = (cnt_reg == '0) || (m_take && (cnt_reg == CNT_W'(1)));
    assign s_take   = s_tvalid && s_tready;

    assign m_tuser = q_reg[0].result_kind;
    assign m_tlast = (cnt_reg == CNT_W'(1));
    assign m_tdata = {4'h0, q_reg[0].sector_done, q_reg[0].word_index,
                      q_reg[0].data_word, q_reg[0].write_value, q_reg[0].port_offset};

    always_comb begin
        st_next  = st_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (s_take) begin
            st_next  = st_step;
            q_next   = step_res;
            cnt_next = step_cnt;
        end else if (m_take) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
            q_next[MAX_RES-1] = '0;
            cnt_next          = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule

// ===== hw/rtl/ata_rd_checker.sv =====
// port-level checks for the sector reader, attached by bind
// depends on ata_rd_pkg
module ata_rd_checker
    import ata_rd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic m_stall;
    logic in_beat;

    assign m_stall = m_tvalid && !m_tready;
    assign in_beat = s_tvalid && s_tready;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_stall |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_stall |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // final sector word closes the run
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[35]) |-> (m_tlast && m_tuser == RK_DATA))
        else $error("sector_done on a beat that is not a final data word");

    // a rejected start is a single beat
    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == RK_REJECT) |-> m_tlast)
        else $error("rejected start not marked last");

    // input beat is never taken while more than one result is pending
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && m_tvalid) |-> (m_tready && m_tlast))
        else $error("input beat taken over pending results");

endmodule

bind ata_pio_sector_reader ata_rd_checker u_ata_rd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
